[hdl/cpc_pkg.sv]
// cpc_pkg: shared constants and types for the convex polygon clipper
// no dependencies; used by the channel interfaces and the top level

package cpc_pkg;

   localparam int MAX_CLIP_VERTS = 16;
   localparam int MAX_WORK_VERTS = 32;

   localparam int COORD_W = 32;
   localparam int WIDX_W  = $clog2(MAX_WORK_VERTS);
   localparam int WCNT_W  = WIDX_W + 1;
   localparam int CIDX_W  = $clog2(MAX_CLIP_VERTS);
   localparam int CCNT_W  = CIDX_W + 1;

   localparam logic OP_SUBJECT = 1'b0;
   localparam logic OP_CLIP    = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vertex_type;

endpackage

[hdl/cpc_req_if.sv]
// cpc_req_if: valid/ready channel for vertex load requests
// depends on cpc_pkg

interface cpc_req_if;
   import cpc_pkg::*;
   logic      valid;
   logic      ready;
   logic      opcode;
   coord_type px;
   coord_type py;
   logic      last;
   modport source (output valid, opcode, px, py, last, input ready);
   modport sink   (input valid, opcode, px, py, last, output ready);
endinterface

[hdl/cpc_rsp_if.sv]
// cpc_rsp_if: valid/ready channel for clipped result vertices
// depends on cpc_pkg

interface cpc_rsp_if;
   import cpc_pkg::*;
   logic      valid;
   logic      ready;
   coord_type qx;
   coord_type qy;
   logic      final_res;
   logic      empty_res;
   logic      overflow;
   modport source (output valid, qx, qy, final_res, empty_res, overflow, input ready);
   modport sink   (input valid, qx, qy, final_res, empty_res, overflow, output ready);
endinterface

[hdl/convex_polygon_clipper.sv]
// convex_polygon_clipper: sutherland-hodgman clipping of a subject polygon
// against a convex clip polygon; depends on cpc_pkg, cpc_req_if, cpc_rsp_if
//
// usage:
//   req_port carries vertex loads: opcode 0 appends a subject vertex, opcode 1
//   a clip vertex. a clip vertex with last set starts a clipping run. loads
//   are taken one per cycle while the block is idle.
//   rsp_port delivers the clipped polygon one vertex per item, final_res on
//   the last one; an empty result is one item with empty_res and final_res.
//   overflow reports that a list was truncated during that load and run.
// cost:
//   a run's length grows with C, the clip vertices, and N, the working
//   vertices in each pass, plus a divide for each coordinate of a cut point;
//   a coordinate that does not change along the edge skips the multiply and
//   the divide. results go out one at a time; the next is read only after
//   the one before is taken. the cost comes from one shared 35x35 multiplier
//   and a radix-2 divider that retires one quotient bit per cycle (34 steps
//   per coordinate). req_port.ready stays low from the starting request
//   until the last result is taken. each result waits in the output register
//   while the receiver stalls; nothing is lost or repeated.
// reset: synchronous, clears the counts, the overflow flag and the sequencer.

module convex_polygon_clipper (
   input logic       clock,
   input logic       reset,
   cpc_req_if.sink   req_port,
   cpc_rsp_if.source rsp_port
);
   import cpc_pkg::*;

   // sequencer codes
   localparam logic [4:0] ST_LOAD = 5'd0;
   localparam logic [4:0] ST_C1   = 5'd1;
   localparam logic [4:0] ST_C2   = 5'd2;
   localparam logic [4:0] ST_C3   = 5'd3;
   localparam logic [4:0] ST_V1   = 5'd4;
   localparam logic [4:0] ST_V2   = 5'd5;
   localparam logic [4:0] ST_V3   = 5'd6;
   localparam logic [4:0] ST_M0   = 5'd7;
   localparam logic [4:0] ST_M1   = 5'd8;
   localparam logic [4:0] ST_M2   = 5'd9;
   localparam logic [4:0] ST_M3   = 5'd10;
   localparam logic [4:0] ST_M4   = 5'd11;
   localparam logic [4:0] ST_CL   = 5'd12;
   localparam logic [4:0] ST_P0   = 5'd13;
   localparam logic [4:0] ST_P1   = 5'd14;
   localparam logic [4:0] ST_P2   = 5'd15;
   localparam logic [4:0] ST_P3   = 5'd16;
   localparam logic [4:0] ST_DIV  = 5'd17;
   localparam logic [4:0] ST_ADD  = 5'd18;
   localparam logic [4:0] ST_NEXT = 5'd19;
   localparam logic [4:0] ST_EDGE = 5'd20;
   localparam logic [4:0] ST_O1   = 5'd21;
   localparam logic [4:0] ST_O2   = 5'd22;
   localparam logic [4:0] ST_O3   = 5'd23;

   localparam int DIV_STEPS = 34;

   // control registers
   logic [4:0]        state_ff, state_in;
   logic              cur_ff, cur_in;
   logic [WCNT_W-1:0] n_ff, n_in, m_ff, m_in, j_ff, j_in;
   logic [CCNT_W-1:0] cc_ff, cc_in, e_ff, e_in;
   logic              ovf_ff, ovf_in;
   logic              axis_ff, axis_in;
   logic              cut_ff, cut_in;
   logic [5:0]        div_cnt_ff, div_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath registers
   vertex_type  v1_ff, v1_in, v3_ff, v3_in, v4_ff, v4_in;
   logic [32:0] ex_ff, ex_in, ey_ff, ey_in;
   logic [69:0] prod_ff, prod_in, acc_ff, acc_in;
   logic [66:0] c3_ff, c3_in, c4_ff, c4_in;
   logic [65:0] c3mag_ff, c3mag_in;
   logic [66:0] denmag_ff, denmag_in;
   logic [32:0] dmag_ff, dmag_in;
   logic        dneg_ff, dneg_in;
   logic [68:0] rem_ff, rem_in;
   logic [33:0] lo_ff, lo_in;
   coord_type   cx_ff, cx_in;
   coord_type   qx_ff, qx_in, qy_ff, qy_in;
   logic        fin_ff, fin_in, emp_ff, emp_in, rovf_ff, rovf_in;

   // memories
   vertex_type work_mem [2*MAX_WORK_VERTS];
   vertex_type clip_mem [MAX_CLIP_VERTS];
   vertex_type wk_q_ff, clip_q_ff;
   logic [WIDX_W:0]   wk_raddr, wk_waddr;
   logic              wk_we;
   vertex_type        wk_wdata;
   logic [CIDX_W-1:0] clip_raddr;
   logic              clip_we;

   // shared multiplier
   logic signed [34:0] mul_a, mul_b;
   logic signed [69:0] mul_p;
   assign mul_p = mul_a * mul_b;

   // helper values
   logic [WCNT_W-1:0] jn;
   logic [CCNT_W-1:0] e2;
   logic [32:0]       dx3, dy3, dx4, dy4, dcoord;
   logic [67:0]       den;
   logic [99:0]       num;
   logic [68:0]       shifted;
   logic [68:0]       den_ext;
   logic              c3_neg, c3_pos, c4_neg, c4_pos;
   coord_type         v3c, v4c, res_c;
   logic [31:0]       off32;
   logic              req_fire, rsp_fire;

   assign req_port.ready = (state_ff == ST_LOAD);
   assign req_fire = req_port.valid && req_port.ready;
   assign rsp_fire = rsp_valid_ff && rsp_port.ready;

   assign jn = (j_ff + 1'b1 == n_ff) ? '0 : j_ff + 1'b1;
   assign e2 = (e_ff + 1'b1 == cc_ff) ? '0 : e_ff + 1'b1;

   assign dx3 = {v3_ff.x[31], v3_ff.x} - {v1_ff.x[31], v1_ff.x};
   assign dy3 = {v3_ff.y[31], v3_ff.y} - {v1_ff.y[31], v1_ff.y};
   assign dx4 = {v4_ff.x[31], v4_ff.x} - {v1_ff.x[31], v1_ff.x};
   assign dy4 = {v4_ff.y[31], v4_ff.y} - {v1_ff.y[31], v1_ff.y};

   assign c3_neg = c3_ff[66];
   assign c3_pos = !c3_ff[66] && (c3_ff != '0);
   assign c4_neg = c4_ff[66];
   assign c4_pos = !c4_ff[66] && (c4_ff != '0);

   assign den = {c3_ff[66], c3_ff} - {c4_ff[66], c4_ff};
   assign v3c = axis_ff ? v3_ff.y : v3_ff.x;
   assign v4c = axis_ff ? v4_ff.y : v4_ff.x;
   assign dcoord = {v4c[31], v4c} - {v3c[31], v3c};

   // numerator of the cut ratio from the two partial products
   assign num = {prod_ff[66:0], 33'd0} + {34'd0, acc_ff[65:0]};
   assign shifted = {rem_ff[67:0], lo_ff[33]};
   assign den_ext = {2'b00, denmag_ff};

   assign off32 = dneg_ff ? (32'd0 - lo_ff[31:0]) : lo_ff[31:0];
   assign res_c = v3c + off32;

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_M0: begin
            mul_a = $signed({{2{ex_ff[32]}}, ex_ff});
            mul_b = $signed({{2{dy3[32]}}, dy3});
         end
         ST_M1: begin
            mul_a = $signed({{2{ey_ff[32]}}, ey_ff});
            mul_b = $signed({{2{dx3[32]}}, dx3});
         end
         ST_M2: begin
            mul_a = $signed({{2{ex_ff[32]}}, ex_ff});
            mul_b = $signed({{2{dy4[32]}}, dy4});
         end
         ST_M3: begin
            mul_a = $signed({{2{ey_ff[32]}}, ey_ff});
            mul_b = $signed({{2{dx4[32]}}, dx4});
         end
         ST_P1: begin
            mul_a = $signed({2'b00, c3mag_ff[32:0]});
            mul_b = $signed({2'b00, dmag_ff});
         end
         ST_P2: begin
            mul_a = $signed({2'b00, c3mag_ff[65:33]});
            mul_b = $signed({2'b00, dmag_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      j_in         = j_ff;
      cc_in        = cc_ff;
      e_in         = e_ff;
      ovf_in       = ovf_ff;
      axis_in      = axis_ff;
      cut_in       = cut_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      v1_in        = v1_ff;
      v3_in        = v3_ff;
      v4_in        = v4_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      c3_in        = c3_ff;
      c4_in        = c4_ff;
      c3mag_in     = c3mag_ff;
      denmag_in    = denmag_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      cx_in        = cx_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      fin_in       = fin_ff;
      emp_in       = emp_ff;
      rovf_in      = rovf_ff;
      wk_raddr     = {cur_ff, j_ff[WIDX_W-1:0]};
      wk_waddr     = {~cur_ff, m_ff[WIDX_W-1:0]};
      wk_we        = 1'b0;
      wk_wdata     = v3_ff;
      clip_raddr   = e_ff[CIDX_W-1:0];
      clip_we      = 1'b0;

      unique case (state_ff)
         // vertex loads
         ST_LOAD: begin
            if (req_fire) begin
               if (req_port.opcode == OP_SUBJECT) begin
                  wk_waddr = {cur_ff, n_ff[WIDX_W-1:0]};
                  wk_wdata = '{x: req_port.px, y: req_port.py};
                  if (n_ff < WCNT_W'(MAX_WORK_VERTS)) begin
                     wk_we = 1'b1;
                     n_in  = n_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  if (cc_ff < CCNT_W'(MAX_CLIP_VERTS)) begin
                     clip_we = 1'b1;
                     cc_in   = cc_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_port.last) begin
                     e_in     = '0;
                     state_in = ST_C1;
                  end
               end
            end
         end
         // fetch clip edge endpoints
         ST_C1: begin
            clip_raddr = e_ff[CIDX_W-1:0];
            state_in   = ST_C2;
         end
         ST_C2: begin
            clip_raddr = e2[CIDX_W-1:0];
            v1_in      = clip_q_ff;
            state_in   = ST_C3;
         end
         ST_C3: begin
            ex_in = {clip_q_ff.x[31], clip_q_ff.x} - {v1_ff.x[31], v1_ff.x};
            ey_in = {clip_q_ff.y[31], clip_q_ff.y} - {v1_ff.y[31], v1_ff.y};
            m_in  = '0;
            j_in  = '0;
            state_in = (n_ff == '0) ? ST_EDGE : ST_V1;
         end
         // fetch subject edge endpoints
         ST_V1: begin
            wk_raddr = {cur_ff, j_ff[WIDX_W-1:0]};
            state_in = ST_V2;
         end
         ST_V2: begin
            wk_raddr = {cur_ff, jn[WIDX_W-1:0]};
            v3_in    = wk_q_ff;
            state_in = ST_V3;
         end
         ST_V3: begin
            v4_in    = wk_q_ff;
            state_in = ST_M0;
         end
         // orientation values through the shared multiplier
         ST_M0: begin
            prod_in  = mul_p;
            state_in = ST_M1;
         end
         ST_M1: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = ST_M2;
         end
         ST_M2: begin
            c3_in    = acc_ff[66:0] - prod_ff[66:0];
            prod_in  = mul_p;
            state_in = ST_M3;
         end
         ST_M3: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = ST_M4;
         end
         ST_M4: begin
            c4_in    = acc_ff[66:0] - prod_ff[66:0];
            state_in = ST_CL;
         end
         // classify the edge and push v3 when it stays
         ST_CL: begin
            c3mag_in  = c3_neg ? 66'(67'd0 - c3_ff) : c3_ff[65:0];
            denmag_in = den[67] ? 67'(68'd0 - den) : den[66:0];
            axis_in   = 1'b0;
            cut_in    = (c3_pos && c4_neg) || (c3_neg && c4_pos);
            // v3 outside is dropped unless v4 lies on the edge line
            if (!c3_neg || !(c4_neg || c4_pos)) begin
               wk_we    = 1'b1;
               wk_wdata = v3_ff;
               if (m_ff < WCNT_W'(MAX_WORK_VERTS)) begin
                  m_in = m_ff + 1'b1;
               end else begin
                  wk_we  = 1'b0;
                  ovf_in = 1'b1;
               end
            end
            if ((c3_pos && c4_neg) || (c3_neg && c4_pos)) begin
               state_in = ST_P0;
            end else begin
               state_in = ST_NEXT;
            end
         end
         // cut point, one coordinate at a time
         ST_P0: begin
            dneg_in = dcoord[32];
            dmag_in = dcoord[32] ? (33'd0 - dcoord) : dcoord;
            if (dcoord == '0) begin
               lo_in    = '0;
               state_in = ST_ADD;
            end else begin
               state_in = ST_P1;
            end
         end
         ST_P1: begin
            prod_in  = mul_p;
            state_in = ST_P2;
         end
         ST_P2: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = ST_P3;
         end
         ST_P3: begin
            rem_in     = {3'd0, num[99:34]};
            lo_in      = num[33:0];
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         // restoring divide, one quotient bit per cycle
         ST_DIV: begin
            if (shifted >= den_ext) begin
               rem_in = shifted - den_ext;
               lo_in  = {lo_ff[32:0], 1'b1};
            end else begin
               rem_in = shifted;
               lo_in  = {lo_ff[32:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (!axis_ff) begin
               cx_in    = res_c;
               axis_in  = 1'b1;
               state_in = ST_P0;
            end else begin
               wk_wdata = '{x: cx_ff, y: res_c};
               if (m_ff < WCNT_W'(MAX_WORK_VERTS)) begin
                  wk_we = 1'b1;
                  m_in  = m_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (j_ff + 1'b1 < n_ff) begin
               j_in     = j_ff + 1'b1;
               state_in = ST_V1;
            end else begin
               state_in = ST_EDGE;
            end
         end
         // swap working lists at the end of a clip edge
         ST_EDGE: begin
            cur_in = ~cur_ff;
            n_in   = m_ff;
            j_in   = '0;
            if (e_ff + 1'b1 < cc_ff) begin
               e_in     = e_ff + 1'b1;
               state_in = ST_C1;
            end else begin
               state_in = ST_O1;
            end
         end
         // result delivery
         ST_O1: begin
            wk_raddr = {cur_ff, j_ff[WIDX_W-1:0]};
            if (n_ff == '0) begin
               qx_in        = '0;
               qy_in        = '0;
               fin_in       = 1'b1;
               emp_in       = 1'b1;
               rovf_in      = ovf_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_O3;
            end else begin
               state_in = ST_O2;
            end
         end
         ST_O2: begin
            qx_in        = wk_q_ff.x;
            qy_in        = wk_q_ff.y;
            fin_in       = (j_ff + 1'b1 == n_ff);
            emp_in       = 1'b0;
            rovf_in      = ovf_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_O3;
         end
         ST_O3: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (fin_ff) begin
                  n_in     = '0;
                  cc_in    = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_O1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cur_ff       <= 1'b0;
         n_ff         <= '0;
         m_ff         <= '0;
         j_ff         <= '0;
         cc_ff        <= '0;
         e_ff         <= '0;
         ovf_ff       <= 1'b0;
         axis_ff      <= 1'b0;
         cut_ff       <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         n_ff         <= n_in;
         m_ff         <= m_in;
         j_ff         <= j_in;
         cc_ff        <= cc_in;
         e_ff         <= e_in;
         ovf_ff       <= ovf_in;
         axis_ff      <= axis_in;
         cut_ff       <= cut_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      v1_ff     <= v1_in;
      v3_ff     <= v3_in;
      v4_ff     <= v4_in;
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      c3_ff     <= c3_in;
      c4_ff     <= c4_in;
      c3mag_ff  <= c3mag_in;
      denmag_ff <= denmag_in;
      dmag_ff   <= dmag_in;
      dneg_ff   <= dneg_in;
      rem_ff    <= rem_in;
      lo_ff     <= lo_in;
      cx_ff     <= cx_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      fin_ff    <= fin_in;
      emp_ff    <= emp_in;
      rovf_ff   <= rovf_in;
   end

   // working lists, two banks
   always_ff @(posedge clock) begin
      if (wk_we) begin
         work_mem[wk_waddr] <= wk_wdata;
      end
      wk_q_ff <= work_mem[wk_raddr];
   end

   // clip polygon store
   always_ff @(posedge clock) begin
      if (clip_we) begin
         clip_mem[cc_ff[CIDX_W-1:0]] <= '{x: req_port.px, y: req_port.py};
      end
      clip_q_ff <= clip_mem[clip_raddr];
   end

   // result port
   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.qx        = qx_ff;
   assign rsp_port.qy        = qy_ff;
   assign rsp_port.final_res = fin_ff;
   assign rsp_port.empty_res = emp_ff;
   assign rsp_port.overflow  = rovf_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (n_ff <= WCNT_W'(MAX_WORK_VERTS)) && (m_ff <= WCNT_W'(MAX_WORK_VERTS)))
      else $error("working count beyond capacity");

   a_empty_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && emp_ff) |-> fin_ff)
      else $error("empty result not marked final");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cut_ff && (denmag_ff != '0)))
      else $error("divide entered without a crossing edge");

   a_busy_no_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_port.ready)
      else $error("load accepted while a result is pending");

endmodule
